// ===== rtl/core/ddsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ddsa_pkg
// Shared constants for the decimal digit stack adder: stack depth, field
// widths, derived address widths and action codes.
// ----------------------------------------------------------------------------
package ddsa_pkg;

  localparam int MAX_DIGITS = 32;

  localparam int ACTION_W = 2;
  localparam int DIGIT_W  = 4;

  // Stack entries, stack fill count (0..MAX_DIGITS), result store entries
  localparam int STACK_AW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int SUM_DEPTH = MAX_DIGITS + 1;
  localparam int SUM_AW    = $clog2(SUM_DEPTH);

  // Column sum: two digits and a carry
  localparam int COL_W = DIGIT_W + 1;

  localparam logic [ACTION_W-1:0] ACT_PUSH_FIRST  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_SECOND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADD         = 2'd2;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [COL_W-1:0]   RADIX     = 5'd10;

endpackage

// ===== rtl/core/ddsa_ram.sv =====
// ----------------------------------------------------------------------------
// ddsa_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ddsa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/decimal_digit_stack_adder.sv =====
// ----------------------------------------------------------------------------
// decimal_digit_stack_adder
// Long decimal addition of two digit streams kept on two stacks.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready, action, digit): action 0 pushes digit on
// the first number's stack, 1 on the second; digits above nine count as nine.
// A push onto a full stack is dropped and sets a sticky dropped flag. Action
// 2 adds: both stacks are popped from the units digit up, one column at a
// time (COL_RD reads both stack RAMs, COL_ADD adds and stores the sum
// digit), then the sum is sent on the output channel (out_valid/out_ready,
// sum_digit, last, dropped) most significant digit first, each digit passing
// through EMIT_RD for the registered read of the result RAM, then EMIT_LD.
// last marks the units digit; dropped carries the flag as it stood before
// the add, which clears it and empties both stacks. An add with both stacks
// empty sends nothing. One word is handled at a time: in_ready is high
// only while no add is in progress. A stalled receiver holds the output
// register and halts the emit walk. Reset empties both stacks, clears the
// flag and drops any pending output; stack and result RAMs need no clearing.
// ----------------------------------------------------------------------------
module decimal_digit_stack_adder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ddsa_pkg::ACTION_W-1:0] action,
  input  logic [ddsa_pkg::DIGIT_W-1:0]  digit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ddsa_pkg::DIGIT_W-1:0]  sum_digit,
  output logic                         last,
  output logic                         dropped
);

  import ddsa_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    COL_RD,
    COL_ADD,
    EMIT_RD,
    EMIT_LD
  } state_t;

  state_t state;

  logic [CNT_W-1:0]    first_count;
  logic [CNT_W-1:0]    second_count;
  logic                drop_flag;
  logic                flag_hold;
  logic                first_use;
  logic                second_use;
  logic                carry;
  logic [SUM_AW-1:0]   sum_count;
  logic [SUM_AW-1:0]   emit_idx;

  logic                accept;
  logic [DIGIT_W-1:0]  push_digit;
  logic                first_we;
  logic                second_we;
  logic [CNT_W-1:0]    first_top;
  logic [CNT_W-1:0]    second_top;
  logic [DIGIT_W-1:0]  first_rdata;
  logic [DIGIT_W-1:0]  second_rdata;
  logic [DIGIT_W-1:0]  sum_rdata;
  logic [COL_W-1:0]    column;
  logic                carry_next;
  logic [DIGIT_W-1:0]  column_digit;
  logic                sum_we;
  logic [SUM_AW-1:0]   sum_raddr;
  logic                out_free;

  assign in_ready   = (state == IDLE);
  assign accept     = in_valid && in_ready;
  assign push_digit = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;

  assign first_we  = accept && (action == ACT_PUSH_FIRST) &&
                     (first_count < CNT_W'(MAX_DIGITS));
  assign second_we = accept && (action == ACT_PUSH_SECOND) &&
                     (second_count < CNT_W'(MAX_DIGITS));

  assign first_top  = first_count - CNT_W'(1);
  assign second_top = second_count - CNT_W'(1);

  // Column add: zero-extend each used digit, then one decimal correction
  assign column = COL_W'(carry) +
                  (first_use  ? COL_W'(first_rdata)  : COL_W'(0)) +
                  (second_use ? COL_W'(second_rdata) : COL_W'(0));
  assign carry_next   = (column >= RADIX);
  assign column_digit = carry_next ? DIGIT_W'(column - RADIX) : DIGIT_W'(column);

  assign sum_we    = (state == COL_ADD);
  assign sum_raddr = emit_idx;
  assign out_free  = !out_valid || out_ready;

  ddsa_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_count[STACK_AW-1:0]),
    .wdata (push_digit),
    .raddr (first_top[STACK_AW-1:0]),
    .rdata (first_rdata)
  );

  ddsa_ram #(.WIDTH(DIGIT_W), .DEPTH(MAX_DIGITS)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_count[STACK_AW-1:0]),
    .wdata (push_digit),
    .raddr (second_top[STACK_AW-1:0]),
    .rdata (second_rdata)
  );

  ddsa_ram #(.WIDTH(DIGIT_W), .DEPTH(SUM_DEPTH)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_count),
    .wdata (column_digit),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      first_count  <= '0;
      second_count <= '0;
      drop_flag    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // drop the output word once taken; EMIT_LD reloads it on its own
      if (out_valid && out_ready && state != EMIT_LD) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (accept) begin
            case (action)
              ACT_PUSH_FIRST: begin
                if (first_we) begin
                  first_count <= first_count + CNT_W'(1);
                end else begin
                  drop_flag <= 1'b1;
                end
              end
              ACT_PUSH_SECOND: begin
                if (second_we) begin
                  second_count <= second_count + CNT_W'(1);
                end else begin
                  drop_flag <= 1'b1;
                end
              end
              ACT_ADD: begin
                flag_hold <= drop_flag;
                drop_flag <= 1'b0;
                carry     <= 1'b0;
                sum_count <= '0;
                if (first_count != '0 || second_count != '0) begin
                  state <= COL_RD;
                end
              end
              default: begin
              end
            endcase
          end
        end

        COL_RD: begin
          // read addresses are the current tops; pop them now
          first_use  <= (first_count != '0);
          second_use <= (second_count != '0);
          if (first_count != '0) begin
            first_count <= first_top;
          end
          if (second_count != '0) begin
            second_count <= second_top;
          end
          state <= COL_ADD;
        end

        COL_ADD: begin
          carry <= carry_next;
          if (first_count != '0 || second_count != '0 || carry_next) begin
            sum_count <= sum_count + SUM_AW'(1);
            state     <= COL_RD;
          end else begin
            emit_idx <= sum_count;
            state    <= EMIT_RD;
          end
        end

        EMIT_RD: begin
          state <= EMIT_LD;
        end

        EMIT_LD: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            sum_digit <= sum_rdata;
            last      <= (emit_idx == '0);
            dropped   <= flag_hold;
            if (emit_idx == '0) begin
              state <= IDLE;
            end else begin
              emit_idx <= emit_idx - SUM_AW'(1);
              state    <= EMIT_RD;
            end
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the decimal digit stack adder against a cycle-free model of its
// digit stacks. Short directed sums come first: an empty add, saturated
// digits, carry chains, a single stack and ignored actions. Random digit
// streams with adds follow, with full and overflowing stacks among them.
// Both channels idle at random. The receiver holds off once for a long
// stretch, and the sender pauses until every sum digit has come back.
// ----------------------------------------------------------------------------
module testbench;

  import ddsa_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int RAND_WORDS  = 180;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [DIGIT_W-1:0]  digit;
    bit                  pause;
  } in_word_t;

  typedef struct {
    logic [DIGIT_W-1:0] sum_digit;
    logic               last;
    logic               dropped;
  } sum_word_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] action    = '0;
  logic [DIGIT_W-1:0]  digit     = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [DIGIT_W-1:0]  sum_digit;
  logic                last;
  logic                dropped;

  decimal_digit_stack_adder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .digit     (digit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sum_digit (sum_digit),
    .last      (last),
    .dropped   (dropped)
  );

  always #6 clk = ~clk;

  in_word_t  word_q[$];
  sum_word_t expected_sum_q[$];

  // Model of the digit stacks
  logic [DIGIT_W-1:0] first_stack [MAX_DIGITS];
  logic [DIGIT_W-1:0] second_stack[MAX_DIGITS];
  int                 first_fill  = 0;
  int                 second_fill = 0;
  bit                 drop_seen   = 1'b0;

  int  cyc          = 0;
  int  fail_cnt     = 0;
  int  word_cnt     = 0;
  int  add_cnt      = 0;
  int  digits_seen  = 0;
  int  drops_seen   = 0;
  int  longest_sum  = 0;
  bit  in_taken     = 1'b0;
  bit  held_once    = 1'b0;
  int  hold_left    = 0;
  int  pause_cnt    = 0;
  logic calm;

  // No random idling on either side inside this window
  assign calm = (cyc >= 600) && (cyc < 1400);

  task automatic predict_sum(logic [ACTION_W-1:0] act, logic [DIGIT_W-1:0] dig);
    logic [DIGIT_W-1:0] d;
    logic [DIGIT_W-1:0] col_digits[SUM_DEPTH];
    int                 col;
    int                 carry;
    int                 n;
    sum_word_t          w;
    d     = (dig > DIGIT_MAX) ? DIGIT_MAX : dig;
    carry = 0;
    n     = 0;
    case (act)
      ACT_PUSH_FIRST: begin
        if (first_fill >= MAX_DIGITS) drop_seen = 1'b1;
        else begin
          first_stack[first_fill] = d;
          first_fill++;
        end
      end
      ACT_PUSH_SECOND: begin
        if (second_fill >= MAX_DIGITS) drop_seen = 1'b1;
        else begin
          second_stack[second_fill] = d;
          second_fill++;
        end
      end
      ACT_ADD: begin
        add_cnt++;
        while ((first_fill > 0 || second_fill > 0 || carry != 0) && n < SUM_DEPTH) begin
          col = carry;
          if (first_fill > 0) begin
            first_fill--;
            col += first_stack[first_fill];
          end
          if (second_fill > 0) begin
            second_fill--;
            col += second_stack[second_fill];
          end
          col_digits[n] = DIGIT_W'(col % 10);
          carry = col / 10;
          n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
          w.sum_digit = col_digits[k];
          w.last      = (k == 0);
          w.dropped   = drop_seen;
          expected_sum_q.push_back(w);
        end
        if (n > longest_sum) longest_sum = n;
        if (drop_seen && n > 0) drops_seen++;
        first_fill  = 0;
        second_fill = 0;
        drop_seen   = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic queue_word(logic [ACTION_W-1:0] act, logic [DIGIT_W-1:0] dig);
    in_word_t w;
    w.action = act;
    w.digit  = dig;
    w.pause  = 1'b0;
    word_q.push_back(w);
    if (act != ACT_NONE) word_cnt++;
  endtask

  task automatic queue_pause();
    in_word_t w;
    w.action = ACT_NONE;
    w.digit  = '0;
    w.pause  = 1'b1;
    word_q.push_back(w);
  endtask

  function automatic logic [DIGIT_W-1:0] rand_digit(bit nines);
    if (nines) return ($urandom_range(0, 3) == 0) ? DIGIT_W'($urandom_range(10, 15)) : DIGIT_MAX;
    if ($urandom_range(0, 5) == 0) return DIGIT_W'($urandom_range(10, 15));
    return DIGIT_W'($urandom_range(0, 9));
  endfunction

  // Interleave the digits of two numbers at random, then add if with_add is set
  task automatic queue_sum(int na, int nb, bit nines, bit with_add);
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        queue_word(ACT_PUSH_FIRST, rand_digit(nines));
        ia++;
      end else begin
        queue_word(ACT_PUSH_SECOND, rand_digit(nines));
        ib++;
      end
      if ($urandom_range(0, 24) == 0) queue_word(ACT_NONE, DIGIT_W'($urandom_range(0, 15)));
    end
    if (with_add) queue_word(ACT_ADD, DIGIT_W'($urandom_range(0, 15)));
  endtask

  function automatic int rand_len();
    if ($urandom_range(0, 14) == 0) return $urandom_range(28, 34);
    return $urandom_range(0, 8);
  endfunction

  always @(posedge clk) begin
    if (!rst) cyc <= cyc + 1;
  end

  // Driver: offer the next word at the falling edge
  always @(negedge clk) begin : drive
    in_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (word_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (word_q[0].pause) begin
        in_valid <= 1'b0;
        // Hold until every sum digit is back, then let the block settle
        if (expected_sum_q.size() != 0) pause_cnt <= 0;
        else if (pause_cnt >= 40) begin
          pause_cnt <= 0;
          void'(word_q.pop_front());
        end else pause_cnt <= pause_cnt + 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        in_valid <= 1'b0;
      end else begin
        w = word_q.pop_front();
        in_valid <= 1'b1;
        action   <= w.action;
        digit    <= w.digit;
      end
    end
  end

  // Receiver: random idling plus one long hold-off mid-sum
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!held_once && digits_seen >= 30) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // Monitor: track accepted words, check each sum digit
  always @(posedge clk) begin : watch
    sum_word_t w;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) predict_sum(action, digit);
      if (out_valid && out_ready) begin
        digits_seen <= digits_seen + 1;
        if (expected_sum_q.size() == 0) begin
          $display("%0t: unexpected sum word: digit %0d last %0b dropped %0b",
                   $time, sum_digit, last, dropped);
          fail_cnt = fail_cnt + 1;
        end else begin
          w = expected_sum_q.pop_front();
          if (sum_digit !== w.sum_digit) begin
            $display("%0t: sum_digit mismatch: expected %0d actual %0d",
                     $time, w.sum_digit, sum_digit);
            fail_cnt = fail_cnt + 1;
          end
          if (last !== w.last) begin
            $display("%0t: last mismatch: expected %0b actual %0b", $time, w.last, last);
            fail_cnt = fail_cnt + 1;
          end
          if (dropped !== w.dropped) begin
            $display("%0t: dropped mismatch: expected %0b actual %0b",
                     $time, w.dropped, dropped);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
  end

  initial begin : run
    int base;
    int seq;
    // Directed sums
    queue_word(ACT_ADD, 4'd0);                       // both stacks empty
    queue_word(ACT_NONE, 4'd5);                      // ignored action
    queue_word(ACT_PUSH_FIRST, 4'd9);
    queue_word(ACT_PUSH_FIRST, 4'd9);
    queue_word(ACT_PUSH_FIRST, 4'd9);
    queue_word(ACT_PUSH_FIRST, 4'd9);
    queue_word(ACT_PUSH_SECOND, 4'd1);
    queue_word(ACT_ADD, 4'd15);                      // carry ripples out
    queue_word(ACT_PUSH_FIRST, 4'd15);               // saturate to nine
    queue_word(ACT_PUSH_SECOND, 4'd10);
    queue_word(ACT_ADD, 4'd0);
    queue_word(ACT_PUSH_FIRST, 4'd0);                // leading zeros kept
    queue_word(ACT_PUSH_FIRST, 4'd0);
    queue_word(ACT_PUSH_FIRST, 4'd5);
    queue_word(ACT_ADD, 4'd0);
    queue_word(ACT_PUSH_SECOND, 4'd0);               // second stack only
    queue_word(ACT_NONE, 4'd15);
    queue_word(ACT_ADD, 4'd0);
    queue_word(ACT_PUSH_FIRST, 4'd8);
    queue_word(ACT_PUSH_SECOND, 4'd7);
    queue_word(ACT_ADD, 4'd0);
    queue_pause();

    // Random sums, with full and overflowing stacks early on
    base = word_cnt;
    seq  = 0;
    while (word_cnt - base < RAND_WORDS) begin
      case (seq)
        0:       queue_sum(MAX_DIGITS, MAX_DIGITS, 1'b1, 1'b1);
        1:       queue_sum(MAX_DIGITS + 1, 1, 1'b0, 1'b1);
        2:       queue_sum(0, MAX_DIGITS + 2, 1'b0, 1'b1);
        default: queue_sum(rand_len(), rand_len(), 1'b0, $urandom_range(0, 9) != 0);
      endcase
      if (seq == 5 || seq == 20) queue_pause();
      seq++;
    end
    queue_word(ACT_ADD, DIGIT_W'($urandom_range(0, 15)));

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (word_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_sum_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d input words and %0d adds; %0d sum digits checked.",
             word_cnt, add_cnt, digits_seen);
    $display("Longest sum %0d digits; %0d sums carried the dropped flag.",
             longest_sum, drops_seen);
    if (fail_cnt == 0 && expected_sum_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== decimal_digit_stack_adder.f =====
rtl/core/ddsa_pkg.sv
rtl/core/ddsa_ram.sv
rtl/core/decimal_digit_stack_adder.sv
sim/testbench.sv
